@@ rtl/drr_pkg.sv @@
// ----------------------------------------------------------------------------
// drr_pkg: shared definitions for the dielectric refract/reflect unit
// Fixed-point constants, pipeline stage numbering and the stage payload type.
// ----------------------------------------------------------------------------
package drr_pkg;

  // fraction bits of directions, normals and most internal quantities; the index has 13
  localparam int FRAC_BITS = 14;
  localparam int IDX_W     = 15;

  // index of 1.0 and the register reset value (1.5)
  localparam logic [IDX_W-1:0] INDEX_ONE   = 15'd8192;
  localparam logic [IDX_W-1:0] INDEX_RESET = 15'd12288;

  // pipeline stage numbers (stage 0 is loaded at the input transfer)
  localparam int ST_SUM     = 1;
  localparam int ST_SQ      = 2;
  localparam int ST_T       = 3;
  localparam int ST_A4      = 4;
  localparam int ST_A5      = 5;
  localparam int ST_DIV0    = 1;
  localparam int DIV_STEPS  = 15;
  localparam int ST_ETA     = ST_DIV0 + DIV_STEPS;
  localparam int ST_KP      = ST_ETA + 1;
  localparam int ST_K       = ST_KP + 1;
  localparam int ST_REFL    = ST_K + 1;
  localparam int ST_SQRT0   = ST_REFL + 1;
  localparam int SQRT_STEPS = 20;
  localparam int ST_NC      = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_OUT     = ST_NC + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // payload carried from stage to stage
  typedef struct {
    logic signed [15:0] d [3];
    logic signed [15:0] nrm [3];
    logic signed [16:0] n [3];
    logic [15:0]        rf;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] prod [3];
    logic               leaving;
    logic signed [18:0] dt;
    logic signed [18:0] d0;
    logic signed [18:0] a;
    logic signed [37:0] dt2;
    logic signed [37:0] a2p;
    logic signed [35:0] nd [3];
    logic signed [35:0] rm [3];
    logic signed [22:0] t;
    logic signed [21:0] u [3];
    logic signed [21:0] orfl [3];
    logic signed [40:0] a3p;
    logic signed [44:0] a4p;
    logic signed [47:0] a5p;
    logic [15:0]        de_rem;
    logic [14:0]        de_low;
    logic [14:0]        de_q;
    logic [15:0]        dr_rem;
    logic [14:0]        dr_low;
    logic [14:0]        dr_q;
    logic [15:0]        dr_div;
    logic [15:0]        eta;
    logic [31:0]        ee_p;
    logic [27:0]        r0_p;
    logic [13:0]        r0;
    logic [14:0]        omr;
    logic signed [41:0] kp;
    logic signed [27:0] k;
    logic               tir;
    logic signed [48:0] reflp;
    logic               refr;
    logic [39:0]        sx;
    logic [20:0]        srem;
    logic [19:0]        sroot;
    logic signed [38:0] eu [3];
    logic signed [37:0] nc [3];
    logic signed [15:0] o [3];
  } stage_t;

endpackage

@@ rtl/dielectric_refract_reflect_unit.sv @@
// ----------------------------------------------------------------------------
// dielectric_refract_reflect_unit: dielectric scatter with Schlick reflectance
// Decides refraction or mirror reflection of one ray hit and gives the
// outgoing direction, all in signed Q2.14 fixed point.
// ----------------------------------------------------------------------------
// One ray hit is taken per clock unless the output stalls, and its result is
// offered on the output once it has passed every pipeline stage; the depth is
// set by the 15-step index divider and the 20-step square root, one step per stage.
// When a result waits at the output with out_tready low the whole pipeline
// holds and in_tready drops with it. The refractive index is read
// from cfg_wr_data when cfg_wr_en is high, in units of 1/8192; values below
// 8192 act as 1.0. It may be written only while no ray is in flight.
module dielectric_refract_reflect_unit (
  input  logic         clk,
  input  logic         rst_n,
  // in_dir_x, in_dir_y, in_dir_z, normal_x, normal_y, normal_z, random_fraction
  input  logic [111:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_dir_x, out_dir_y, out_dir_z
  output logic [47:0]  out_tdata,
  // refracted, total_internal, leaving_medium
  output logic [2:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [14:0]  cfg_wr_data
);

  localparam int FB   = drr_pkg::FRAC_BITS;
  localparam int NST  = drr_pkg::NUM_STAGES;
  localparam int LAST = NST - 1;

  logic [14:0]     ridx_r;
  logic            en;
  logic [NST-1:0]  vld_r;
  drr_pkg::stage_t stg_r   [NST];
  drr_pkg::stage_t stg_nxt [NST];

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7FFF;
    end
    if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // refractive index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridx_r <= drr_pkg::INDEX_RESET;
    end else if (cfg_wr_en) begin
      ridx_r <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless the output holds an untaken result
  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en;

  // stage logic
  always_comb begin
    drr_pkg::stage_t p;
    logic signed [33:0] s0_v;
    logic signed [33:0] s1_v;
    logic               lv;
    logic [14:0]        idx_v;
    logic [14:0]        diff_v;
    logic [16:0]        rem2_v;
    logic [22:0]        srem2_v;
    logic [22:0]        trial_v;
    logic signed [36:0] refl4_v;
    logic signed [34:0] refl_v;
    logic signed [23:0] orr_v;

    s0_v    = '0;
    s1_v    = '0;
    lv      = 1'b0;
    rem2_v  = '0;
    srem2_v = '0;
    trial_v = '0;
    refl4_v = '0;
    refl_v  = '0;
    orr_v   = '0;

    // stage 0: unpack, clamp index, products of the leave test, divider setup
    p = '{default: '0};
    for (int c = 0; c < 3; c++) begin
      p.d[c]    = $signed(in_tdata[16*c +: 16]);
      p.nrm[c]  = $signed(in_tdata[48 + 16*c +: 16]);
      p.prod[c] = p.d[c] * p.nrm[c];
    end
    p.rf   = in_tdata[111:96];
    idx_v  = (ridx_r < drr_pkg::INDEX_ONE) ? drr_pkg::INDEX_ONE : ridx_r;
    diff_v = idx_v - drr_pkg::INDEX_ONE;
    p.idx  = idx_v;
    // eta on entry: 2^27 / idx; r: (idx - 1) << 14 / (idx + 1)
    p.de_rem = 16'd4096;
    p.de_low = '0;
    p.de_q   = '0;
    p.dr_rem = {2'b00, diff_v[14:1]};
    p.dr_low = {diff_v[0], 14'b0};
    p.dr_q   = '0;
    p.dr_div = {1'b0, idx_v} + {1'b0, drr_pkg::INDEX_ONE};
    stg_nxt[0] = p;

    for (int s = 1; s < NST; s++) begin
      p = stg_r[s-1];

      // leave test, flipped normal, dt and the reflection dot
      if (s == drr_pkg::ST_SUM) begin
        s0_v = p.prod[0] + p.prod[1] + p.prod[2];
        lv   = s0_v > 34'sd0;
        s1_v = lv ? -s0_v : s0_v;
        p.leaving = lv;
        for (int c = 0; c < 3; c++) begin
          p.n[c] = lv ? -$signed({p.nrm[c][15], p.nrm[c]})
                      : $signed({p.nrm[c][15], p.nrm[c]});
        end
        p.dt = s1_v[FB+18:FB];
        p.d0 = s0_v[FB+18:FB];
        p.a  = s1_v[FB+18:FB] + 19'sd16384;
      end

      // squares and per-axis products
      if (s == drr_pkg::ST_SQ) begin
        p.dt2 = p.dt * p.dt;
        p.a2p = p.a * p.a;
        for (int c = 0; c < 3; c++) begin
          p.nd[c] = p.n[c] * p.dt;
          p.rm[c] = $signed({p.d0, 1'b0}) * p.nrm[c];
        end
      end

      // t = 1 - dt^2, (1 + dt)^3, tangent part and mirror direction
      if (s == drr_pkg::ST_T) begin
        p.t   = 23'sd16384 - $signed(p.dt2[FB+22:FB]);
        p.a3p = $signed({1'b0, p.a2p[FB+20:FB]}) * p.a;
        for (int c = 0; c < 3; c++) begin
          p.u[c]    = p.d[c] - $signed(p.nd[c][FB+19:FB]);
          p.orfl[c] = p.d[c] - $signed(p.rm[c][FB+20:FB]);
        end
      end

      // powers of (1 + dt)
      if (s == drr_pkg::ST_A4) begin
        p.a4p = $signed(p.a3p[FB+25:FB]) * p.a;
      end
      if (s == drr_pkg::ST_A5) begin
        p.a5p = $signed(p.a4p[FB+28:FB]) * p.a;
      end

      // one restoring step of both index quotients
      if (s >= drr_pkg::ST_DIV0 && s < drr_pkg::ST_DIV0 + drr_pkg::DIV_STEPS) begin
        rem2_v = {p.de_rem, p.de_low[14]};
        p.de_low = {p.de_low[13:0], 1'b0};
        if (rem2_v >= {2'b00, p.idx}) begin
          p.de_rem = 16'(rem2_v - {2'b00, p.idx});
          p.de_q   = {p.de_q[13:0], 1'b1};
        end else begin
          p.de_rem = rem2_v[15:0];
          p.de_q   = {p.de_q[13:0], 1'b0};
        end
        rem2_v = {p.dr_rem, p.dr_low[14]};
        p.dr_low = {p.dr_low[13:0], 1'b0};
        if (rem2_v >= {1'b0, p.dr_div}) begin
          p.dr_rem = 16'(rem2_v - {1'b0, p.dr_div});
          p.dr_q   = {p.dr_q[13:0], 1'b1};
        end else begin
          p.dr_rem = rem2_v[15:0];
          p.dr_q   = {p.dr_q[13:0], 1'b0};
        end
      end

      // eta by direction, eta^2 and r^2
      if (s == drr_pkg::ST_ETA) begin
        p.eta  = p.leaving ? {p.idx, 1'b0} : {1'b0, p.de_q};
        p.ee_p = p.eta * p.eta;
        p.r0_p = p.dr_q[13:0] * p.dr_q[13:0];
      end

      // eta^2 * t and 1 - r0
      if (s == drr_pkg::ST_KP) begin
        p.kp  = $signed({1'b0, p.ee_p[FB+17:FB]}) * p.t;
        p.r0  = p.r0_p[FB+13:FB];
        p.omr = 15'd16384 - {1'b0, p.r0_p[FB+13:FB]};
      end

      // k and the Schlick product
      if (s == drr_pkg::ST_K) begin
        p.k     = 28'sd16384 - $signed(p.kp[FB+26:FB]);
        p.tir   = p.k < 28'sd0;
        p.reflp = $signed({1'b0, p.omr}) * $signed(p.a5p[FB+32:FB]);
      end

      // reflectance against the random value, root setup, eta * tangent
      if (s == drr_pkg::ST_REFL) begin
        refl_v  = $signed({1'b0, p.r0}) + $signed(p.reflp[FB+32:FB]);
        refl4_v = {refl_v, 2'b00};
        p.refr  = !p.tir && (refl4_v <= $signed({1'b0, p.rf}));
        p.sx    = p.tir ? 40'd0 : {p.k[25:0], 14'b0};
        p.srem  = '0;
        p.sroot = '0;
        for (int c = 0; c < 3; c++) begin
          p.eu[c] = $signed({1'b0, p.eta}) * p.u[c];
        end
      end

      // one digit of the square root of k
      if (s >= drr_pkg::ST_SQRT0 && s < drr_pkg::ST_SQRT0 + drr_pkg::SQRT_STEPS) begin
        srem2_v = {p.srem, p.sx[39:38]};
        trial_v = {1'b0, p.sroot, 2'b01};
        p.sx    = {p.sx[37:0], 2'b00};
        if (srem2_v >= trial_v) begin
          p.srem  = 21'(srem2_v - trial_v);
          p.sroot = {p.sroot[18:0], 1'b1};
        end else begin
          p.srem  = srem2_v[20:0];
          p.sroot = {p.sroot[18:0], 1'b0};
        end
      end

      // normal times cos of the refracted angle
      if (s == drr_pkg::ST_NC) begin
        for (int c = 0; c < 3; c++) begin
          p.nc[c] = p.n[c] * $signed({1'b0, p.sroot});
        end
      end

      // pick direction and saturate
      if (s == drr_pkg::ST_OUT) begin
        for (int c = 0; c < 3; c++) begin
          orr_v  = $signed(p.eu[c][FB+21:FB]) - $signed(p.nc[c][FB+22:FB]);
          p.o[c] = p.refr ? sat16(orr_v) : sat16(24'(p.orfl[c]));
        end
      end

      stg_nxt[s] = p;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // result transfer
  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {stg_r[LAST].o[2], stg_r[LAST].o[1], stg_r[LAST].o[0]};
  assign out_tuser  = {stg_r[LAST].leaving, stg_r[LAST].tir, stg_r[LAST].refr};

endmodule

@@ rtl/drr_chk.sv @@
// ----------------------------------------------------------------------------
// drr_chk: port checker for the dielectric refract/reflect unit
// Watches the stream ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module drr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // total internal reflection never reports refraction
  a_tir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[0]))
    else $error("refracted flagged with total internal reflection");

  // empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

endmodule

bind dielectric_refract_reflect_unit drr_chk u_drr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/dielectric_refract_reflect_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dielectric_refract_reflect_unit_tb: self-checking bench for the scatter unit
// Streams ray hits with random gaps and stalls on both sides, predicts each
// outgoing direction and flag set in fixed point, and compares every result
// transfer in order. The refractive index is rewritten between phases.
// ----------------------------------------------------------------------------
module dielectric_refract_reflect_unit_tb;

  localparam longint SAT_MAG  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam int     FB       = drr_pkg::FRAC_BITS;
  localparam int     MAX_IDLE = 11;
  localparam int     WD_LIMIT = 4000;
  localparam int     DRAIN    = 60;

  typedef struct packed {
    logic [15:0] rf;
    logic [15:0] nz, ny, nx;
    logic [15:0] dz, dy, dx;
  } hit_t;

  typedef struct {
    logic [15:0] ox, oy, oz;
    logic [2:0]  flags;
  } scatter_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [111:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [14:0]  cfg_wr_data = '0;

  int  n_errors = 0;
  int  quiet_cycles = 0;
  bit  hold_off = 1'b0;

  always #6 clk = ~clk;

  dielectric_refract_reflect_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  // fixed-point helpers
  function automatic longint sat_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > SAT_MAG) return SAT_MAG;
    if (s < -SAT_MAG) return -SAT_MAG;
    return s;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = 128'(a) * 128'(b);
    q = p >>> FB;
    if (q > SAT_MAG) return SAT_MAG;
    if (q < -SAT_MAG) return -SAT_MAG;
    return longint'(q);
  endfunction

  function automatic longint floor_frac(input longint v);
    return v >>> FB;
  endfunction

  function automatic longint int_sqrt(input longint x);
    longint r, lo, hi, m;
    lo = 0; hi = 64'd3037000500;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      if (m * m <= x) lo = m; else hi = m - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // predicted scatter of one hit at the given index
  function automatic scatter_t scatter_of(input hit_t h, input logic [14:0] index);
    longint d[3], nrm[3], n[3], o[3];
    longint one, s0, s1, idx, i1, i2, eta, dt, d0, t, k, diff, r, r0, a, a5, refl;
    longint kc, cost;
    bit leaving, tir, refr;
    scatter_t res;
    one = 64'sd1 << FB;
    d[0] = longint'($signed(h.dx)); d[1] = longint'($signed(h.dy));
    d[2] = longint'($signed(h.dz));
    nrm[0] = longint'($signed(h.nx)); nrm[1] = longint'($signed(h.ny));
    nrm[2] = longint'($signed(h.nz));
    s0 = 0; s1 = 0; refr = 1'b0;
    for (int c = 0; c < 3; c++) s0 += d[c] * nrm[c];
    leaving = s0 > 0;
    for (int c = 0; c < 3; c++) begin
      n[c] = leaving ? -nrm[c] : nrm[c];
      s1 += d[c] * n[c];
    end
    idx = longint'(index);
    if (idx < 8192) idx = 8192;
    i1 = leaving ? idx : 8192;
    i2 = leaving ? 8192 : idx;
    eta = (i1 << FB) / i2;
    dt = floor_frac(s1);
    t = sat_add(one, -fx_mul(dt, dt));
    k = sat_add(one, -fx_mul(fx_mul(eta, eta), t));
    tir = k < 0;
    d0 = floor_frac(s0);
    for (int c = 0; c < 3; c++) o[c] = sat_add(d[c], -fx_mul(2 * d0, nrm[c]));
    if (!tir) begin
      diff = i1 > i2 ? i1 - i2 : i2 - i1;
      r = (diff << FB) / (i1 + i2);
      r0 = fx_mul(r, r);
      a = sat_add(one, dt);
      a5 = fx_mul(fx_mul(fx_mul(fx_mul(a, a), a), a), a);
      refl = sat_add(r0, fx_mul(sat_add(one, -r0), a5));
      if (refl < 0) refr = 1'b1;
      else if (refl > one) refr = 1'b0;
      else refr = (longint'(h.rf) << FB) >= (refl << 16);
      if (refr) begin
        kc = k > (64'sd1 << (62 - FB)) ? (64'sd1 << (62 - FB)) : k;
        cost = int_sqrt(kc << FB);
        for (int c = 0; c < 3; c++)
          o[c] = sat_add(fx_mul(eta, sat_add(d[c], -fx_mul(n[c], dt))),
                         -fx_mul(n[c], cost));
      end
    end
    res.ox = clip16(o[0]); res.oy = clip16(o[1]); res.oz = clip16(o[2]);
    res.flags = {leaving, tir, refr};
    return res;
  endfunction

  // scoreboard: pending scatter results in arrival order
  class scatter_board;
    scatter_t    pending[$];
    logic [14:0] index = drr_pkg::INDEX_RESET;

    function void note_hit(hit_t h);
      pending.push_back(scatter_of(h, index));
    endfunction

    task check_result(logic [47:0] data, logic [2:0] flags);
      scatter_t e;
      if (pending.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.ox)
        report_mismatch($sformatf("out_dir_x %h exp %h", data[15:0], e.ox));
      if (data[31:16] !== e.oy)
        report_mismatch($sformatf("out_dir_y %h exp %h", data[31:16], e.oy));
      if (data[47:32] !== e.oz)
        report_mismatch($sformatf("out_dir_z %h exp %h", data[47:32], e.oz));
      if (flags[0] !== e.flags[0])
        report_mismatch($sformatf("refracted %b exp %b", flags[0], e.flags[0]));
      if (flags[1] !== e.flags[1])
        report_mismatch($sformatf("total_internal %b exp %b", flags[1], e.flags[1]));
      if (flags[2] !== e.flags[2])
        report_mismatch($sformatf("leaving_medium %b exp %b", flags[2], e.flags[2]));
    endtask
  endclass

  scatter_board board = new();

  // transfer monitors and idle watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_hit(hit_t'(in_tdata));
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap, hold;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        hold = 0;
        while (hold < 300) begin
          @(posedge clk);
          hold++;
        end
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_hit(input hit_t h, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= h;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_index(input logic [14:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.index = v;
    @(posedge clk);
  endtask

  // random unit-ish vector: a few axis-heavy forms plus raw noise
  function automatic logic [47:0] rand_vec();
    logic [15:0] v[3];
    int sel;
    sel = $urandom_range(0, 9);
    for (int c = 0; c < 3; c++) v[c] = 16'($signed($urandom_range(0, 9000)) - 4500);
    if (sel < 6) begin
      v[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'($urandom_range(13000, 16384))
                                                      : -16'($urandom_range(13000, 16384));
    end else if (sel < 8) begin
      for (int c = 0; c < 3; c++) v[c] = 16'($signed($urandom_range(0, 18918)) - 9459);
    end else begin
      for (int c = 0; c < 3; c++) v[c] = 16'($urandom());
    end
    return {v[2], v[1], v[0]};
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    {h.dz, h.dy, h.dx} = rand_vec();
    {h.nz, h.ny, h.nx} = rand_vec();
    h.rf = 16'($urandom());
    return h;
  endfunction

  function automatic hit_t mk_hit(input int dx, dy, dz, nx, ny, nz, rf);
    hit_t h;
    h.dx = 16'(dx); h.dy = 16'(dy); h.dz = 16'(dz);
    h.nx = 16'(nx); h.ny = 16'(ny); h.nz = 16'(nz); h.rf = 16'(rf);
    return h;
  endfunction

  // stimulus
  initial begin
    logic [14:0] idx_set[6];
    hit_t dir[$];
    idx_set = '{15'd8192, 15'd32767, 15'd0, 15'd16384, 15'd12288, 15'd8191};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: head-on entry, leaving, grazing, tir, extremes, random ends
    dir.push_back(mk_hit(0, 0, -16384, 0, 0, 16384, 0));
    dir.push_back(mk_hit(0, 0, -16384, 0, 0, 16384, 65535));
    dir.push_back(mk_hit(0, 0, 16384, 0, 0, 16384, 0));
    dir.push_back(mk_hit(16384, 0, 0, 0, 0, 16384, 30000));
    dir.push_back(mk_hit(11585, 0, 11585, 0, 0, 16384, 40000));
    dir.push_back(mk_hit(15000, 0, 6000, 0, 0, 16384, 65535));
    dir.push_back(mk_hit(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
    dir.push_back(mk_hit(32767, 32767, 32767, 32767, 32767, 32767, 0));
    dir.push_back(mk_hit(-32768, 32767, -32768, -32768, 32767, -32768, 12345));
    dir.push_back(mk_hit(0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_hit(1, 0, 0, 1, 0, 0, 65535));
    dir.push_back(mk_hit(11585, 11585, 0, 0, -16384, 0, 32768));
    dir.push_back(mk_hit(-5000, 14000, -6000, 0, 16384, 0, 100));
    dir.push_back(mk_hit(16384, 16384, 16384, -16384, -16384, -16384, 65535));
    foreach (dir[i]) send_hit(dir[i], 1'b0);
    wait_drained();

    // random phases across index settings, one with a long output hold-off
    for (int p = 0; p < 6; p++) begin
      write_index(idx_set[p]);
      if (p == 2) hold_off = 1'b1;
      for (int i = 0; i < 240; i++) send_hit(rand_hit(), $urandom_range(0, 3) == 0 || p == 2);
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
